/* rtl/core/mma_pkg.sv */
// ----------------------------------------------------------------------------
// mma_pkg
// Shared constants and types for the multichannel moving-average filter.
// ----------------------------------------------------------------------------
package mma_pkg;

  // Number of sample channels carried by one request.
  localparam int NUM_CH = 4;

  // Width of the window length register.
  localparam int CFG_W = 7;

  // Window length after reset.
  localparam int CFG_LEN_RESET = 8;

  // Default parameter values.
  localparam int WINDOW_MAX_DEF  = 64;
  localparam int SAMPLE_BITS_DEF = 16;

  // Per-request control handed from the sequencer to every lane.
  typedef struct packed {
    logic clear;   // drop the running sum (new window)
    logic rd_en;   // request accepted: fetch the oldest sample, latch the new one
    logic upd;     // update the running sum and write the new sample
    logic full;    // window was full when the request arrived
  } lane_ctrl_t;

endpackage

/* rtl/core/multichannel_moving_average.sv */
// ----------------------------------------------------------------------------
// multichannel_moving_average
// Four-channel boxcar moving-average filter with fault flag pass-through.
// ----------------------------------------------------------------------------
// Usage: each request on the input channel (in_valid_i / in_ready_o) carries
// one signed sample for x position, y position, angle and temperature, plus
// two fault flags. Each request yields exactly one result on the output
// channel (out_valid_o / out_ready_i): the truncated mean of the last
// window_length samples of every channel, and the flags unchanged. While a
// window is still filling, the mean is taken over the samples held so far.
// The user must write the window length through cfg_we_i / cfg_wdata_i only
// while the block is idle; the block does not enforce this. Zero acts as one,
// values above WINDOW_MAX saturate, and any write empties all histories.
// After acceptance, a request passes through the update step (S_UPD), the
// divider launch (S_WAIT) and the bit-serial divider in each lane (S_DIV),
// one quotient bit per cycle, before the output register takes the result.
// The four lanes run side by side; the output register merges their quotients.
// Reset empties all windows and sets the window length to eight. A new
// request is taken while a finished result still waits in the output
// register; if the receiver stalls longer, the next result waits in the
// lanes until the output register is free.
// ----------------------------------------------------------------------------
module multichannel_moving_average
  import mma_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration
  input  logic                          cfg_we_i,
  input  logic        [CFG_W-1:0]       cfg_wdata_i,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic signed [SAMPLE_BITS-1:0] pos_x_in_i,
  input  logic signed [SAMPLE_BITS-1:0] pos_y_in_i,
  input  logic signed [SAMPLE_BITS-1:0] angle_in_i,
  input  logic signed [SAMPLE_BITS-1:0] temp_in_i,
  input  logic                          fault_elec_in_i,
  input  logic                          fault_hyd_in_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0] pos_x_out_o,
  output logic signed [SAMPLE_BITS-1:0] pos_y_out_o,
  output logic signed [SAMPLE_BITS-1:0] angle_out_o,
  output logic signed [SAMPLE_BITS-1:0] temp_out_o,
  output logic                          fault_elec_out_o,
  output logic                          fault_hyd_out_o
);

  localparam int ADDR_W = $clog2(WINDOW_MAX);
  localparam int CNT_W  = $clog2(WINDOW_MAX + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a request
  localparam logic [1:0] S_UPD  = 2'd1;  // running sums and history updated
  localparam logic [1:0] S_WAIT = 2'd2;  // dividers being launched
  localparam logic [1:0] S_DIV  = 2'd3;  // dividers running, then result out

  // Effective window length: zero means one, large values saturate.
  function automatic logic [CNT_W-1:0] eff_len(input logic [CFG_W-1:0] v);
    logic [CNT_W-1:0] r;
    if (v == '0) begin
      r = CNT_W'(1);
    end else if (int'(v) > WINDOW_MAX) begin
      r = CNT_W'(WINDOW_MAX);
    end else begin
      r = CNT_W'(v);
    end
    return r;
  endfunction

  logic [1:0]        state_q, state_d;
  logic [CNT_W-1:0]  len_q;
  logic [CNT_W-1:0]  fill_q;
  logic [ADDR_W-1:0] slot_q;
  logic              full_q;
  logic              felec_q, fhyd_q;

  logic              in_acc;
  logic              out_free;
  logic              all_done;
  logic              load_out;
  logic [CNT_W:0]    slot_inc;
  lane_ctrl_t        ctrl;

  logic signed [SAMPLE_BITS-1:0] samp [NUM_CH];
  logic signed [SAMPLE_BITS-1:0] mean [NUM_CH];
  logic        [NUM_CH-1:0]      done;

  logic signed [SAMPLE_BITS-1:0] res_q [NUM_CH];
  logic                          res_felec_q, res_fhyd_q;
  logic                          out_valid_q;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign all_done   = &done;
  assign load_out   = (state_q == S_DIV) && all_done && out_free;

  // Next write position wraps at the effective window length.
  assign slot_inc = {1'b0, CNT_W'(slot_q)} + 1'b1;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_UPD;
        end
      end
      S_UPD:  state_d = S_WAIT;
      S_WAIT: state_d = S_DIV;
      S_DIV: begin
        if (load_out) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      len_q   <= eff_len(CFG_W'(CFG_LEN_RESET));
      fill_q  <= '0;
      slot_q  <= '0;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        // A new window length starts with empty histories.
        len_q  <= eff_len(cfg_wdata_i);
        fill_q <= '0;
        slot_q <= '0;
      end else if (state_q == S_UPD) begin
        if (!full_q) begin
          fill_q <= fill_q + 1'b1;
        end
        slot_q <= (slot_inc >= {1'b0, len_q}) ? '0 : ADDR_W'(slot_inc);
      end
      if (in_acc) begin
        full_q <= (fill_q >= len_q);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      felec_q <= fault_elec_in_i;
      fhyd_q  <= fault_hyd_in_i;
    end
  end

  assign ctrl.clear = cfg_we_i;
  assign ctrl.rd_en = in_acc;
  assign ctrl.upd   = (state_q == S_UPD);
  assign ctrl.full  = full_q;

  assign samp[0] = pos_x_in_i;
  assign samp[1] = pos_y_in_i;
  assign samp[2] = angle_in_i;
  assign samp[3] = temp_in_i;

  for (genvar g = 0; g < NUM_CH; g++) begin : g_lane
    mma_lane #(
      .WINDOW_MAX  (WINDOW_MAX),
      .SAMPLE_BITS (SAMPLE_BITS),
      .ADDR_W      (ADDR_W),
      .CNT_W       (CNT_W)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .slot_i   (slot_q),
      .sample_i (samp[g]),
      .count_i  (fill_q),
      .mean_o   (mean[g]),
      .done_o   (done[g])
    );
  end

  // Merge stage: the output register gathers all four lane results at once.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      for (int c = 0; c < NUM_CH; c++) begin
        res_q[c] <= mean[c];
      end
      res_felec_q <= felec_q;
      res_fhyd_q  <= fhyd_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign pos_x_out_o      = res_q[0];
  assign pos_y_out_o      = res_q[1];
  assign angle_out_o      = res_q[2];
  assign temp_out_o       = res_q[3];
  assign fault_elec_out_o = res_felec_q;
  assign fault_hyd_out_o  = res_fhyd_q;

endmodule

/* rtl/core/mma_div.sv */
// ----------------------------------------------------------------------------
// mma_div
// Restoring divider, one quotient bit per cycle. Divides a signed running sum
// by an unsigned sample count and truncates the quotient toward zero.
// ----------------------------------------------------------------------------
module mma_div #(
  parameter int SUM_W       = 22,
  parameter int CNT_W       = 7,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic signed [SUM_W-1:0]       dividend_i,
  input  logic        [CNT_W-1:0]       divisor_i,
  output logic signed [SAMPLE_BITS-1:0] quot_o,
  output logic                          done_o
);

  localparam int STEP_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  mag_q;
  logic [CNT_W-1:0]  rem_q;
  logic [CNT_W-1:0]  dvs_q;
  logic              neg_q;
  logic [STEP_W-1:0] cnt_q;
  logic              busy_q;
  logic              done_q;

  logic [CNT_W:0]    trial;
  logic              fits;
  logic [SAMPLE_BITS-1:0] qmag;

  assign trial = {rem_q, mag_q[SUM_W-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= STEP_W'(SUM_W - 1);
    end else if (busy_q) begin
      if (cnt_q == '0) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // Datapath: the magnitude register shifts left and fills with quotient bits.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[SUM_W-1];
      mag_q <= dividend_i[SUM_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      mag_q <= {mag_q[SUM_W-2:0], fits};
      rem_q <= fits ? CNT_W'(trial - {1'b0, dvs_q}) : trial[CNT_W-1:0];
    end
  end

  assign qmag   = mag_q[SAMPLE_BITS-1:0];
  assign quot_o = neg_q ? signed'(~qmag + 1'b1) : signed'(qmag);
  assign done_o = done_q;

endmodule

/* rtl/core/mma_lane.sv */
// ----------------------------------------------------------------------------
// mma_lane
// One channel of the filter: sample history memory, running sum and divider.
// ----------------------------------------------------------------------------
module mma_lane
  import mma_pkg::*;
#(
  parameter int WINDOW_MAX  = WINDOW_MAX_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  parameter int ADDR_W      = $clog2(WINDOW_MAX),
  parameter int CNT_W       = $clog2(WINDOW_MAX + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  lane_ctrl_t                    ctrl_i,
  input  logic        [ADDR_W-1:0]      slot_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic        [CNT_W-1:0]       count_i,
  output logic signed [SAMPLE_BITS-1:0] mean_o,
  output logic                          done_o
);

  localparam int SUM_W = SAMPLE_BITS + $clog2(WINDOW_MAX);
  localparam int EXT_W = SUM_W - SAMPLE_BITS;

  logic signed [SAMPLE_BITS-1:0] mem [WINDOW_MAX];
  logic signed [SAMPLE_BITS-1:0] old_q;
  logic signed [SAMPLE_BITS-1:0] new_q;
  logic signed [SUM_W-1:0]       sum_q, sum_d;
  logic signed [SUM_W-1:0]       old_ext, new_ext;
  logic                          start_q;

  // History memory: read registered at acceptance, written in the update cycle.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      old_q <= mem[slot_i];
      new_q <= sample_i;
    end
    if (ctrl_i.upd) begin
      mem[slot_i] <= new_q;
    end
  end

  assign old_ext = {{EXT_W{old_q[SAMPLE_BITS-1]}}, old_q};
  assign new_ext = {{EXT_W{new_q[SAMPLE_BITS-1]}}, new_q};
  assign sum_d   = sum_q - (ctrl_i.full ? old_ext : '0) + new_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q   <= '0;
      start_q <= 1'b0;
    end else begin
      start_q <= ctrl_i.upd;
      if (ctrl_i.clear) begin
        sum_q <= '0;
      end else if (ctrl_i.upd) begin
        sum_q <= sum_d;
      end
    end
  end

  mma_div #(
    .SUM_W       (SUM_W),
    .CNT_W       (CNT_W),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start_q),
    .dividend_i (sum_q),
    .divisor_i  (count_i),
    .quot_o     (mean_o),
    .done_o     (done_o)
  );

endmodule
